// ===== design/frsq_pkg.sv =====
// Shared constants and leading-zero helpers for the reciprocal square root pipeline.
`timescale 1ns / 1ps
package frsq_pkg;

  // Single-precision constants of the estimate and the Newton step.
  localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
  localparam logic [31:0] FP_HALF = 32'h3f000000;
  localparam logic [31:0] FP_THREE_HALF = 32'h3fc00000;
  localparam logic [31:0] CANON_NAN = 32'h7fc00000;

  // Pipeline depths of the arithmetic units.
  localparam int MUL_LAT = 4;
  localparam int ADD_LAT = 6;
  localparam int TOTAL_LAT = 4 * MUL_LAT + ADD_LAT;
  localparam int YDL_LEN = 3 * MUL_LAT + ADD_LAT;

  // Leading zeros of a 48-bit product; 48 when the word is zero.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic hit;
    n = 6'd48;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n = 6'(47 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Leading zeros of a 27-bit sum; 27 when the word is zero.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic hit;
    n = 5'd27;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n = 5'(26 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== design/frsq_fmul.sv =====
// Four-stage single-precision multiplier, round to nearest even, subnormals kept.
`timescale 1ns / 1ps
module frsq_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a_bits,
  input  logic [31:0] b_bits,
  output logic [31:0] p_bits
);
  import frsq_pkg::*;

  // Stage 1: unpack, special operands, mantissa product.
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;
  logic        spec;
  logic [31:0] spec_bits;

  always_comb begin
    a_nan  = (&a_bits[30:23]) && (|a_bits[22:0]);
    b_nan  = (&b_bits[30:23]) && (|b_bits[22:0]);
    a_inf  = (&a_bits[30:23]) && !(|a_bits[22:0]);
    b_inf  = (&b_bits[30:23]) && !(|b_bits[22:0]);
    a_zero = !(|a_bits[30:0]);
    b_zero = !(|b_bits[30:0]);
    sgn    = a_bits[31] ^ b_bits[31];
    ma     = {|a_bits[30:23], a_bits[22:0]};
    mb     = {|b_bits[30:23], b_bits[22:0]};
    ea     = (|a_bits[30:23]) ? a_bits[30:23] : 8'd1;
    eb     = (|b_bits[30:23]) ? b_bits[30:23] : 8'd1;
    spec   = 1'b1;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      spec_bits = CANON_NAN;
    end else if (a_inf || b_inf) begin
      spec_bits = {sgn, 8'hff, 23'd0};
    end else if (a_zero || b_zero) begin
      spec_bits = {sgn, 31'd0};
    end else begin
      spec      = 1'b0;
      spec_bits = {sgn, 31'd0};
    end
  end

  logic [47:0]       prod1_r;
  logic signed [9:0] epre1_r;
  logic              sgn1_r, spec1_r;
  logic [31:0]       sbits1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r  <= ma * mb;
      epre1_r  <= signed'({2'b00, ea}) + signed'({2'b00, eb}) - 10'sd126;
      sgn1_r   <= sgn;
      spec1_r  <= spec;
      sbits1_r <= spec_bits;
    end
  end

  // Stage 2: leading-zero count of the product.
  logic [47:0]       prod2_r;
  logic signed [9:0] epre2_r;
  logic [5:0]        lz2_r;
  logic              sgn2_r, spec2_r;
  logic [31:0]       sbits2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod2_r  <= prod1_r;
      epre2_r  <= epre1_r;
      lz2_r    <= lzc48(prod1_r);
      sgn2_r   <= sgn1_r;
      spec2_r  <= spec1_r;
      sbits2_r <= sbits1_r;
    end
  end

  // Stage 3: normalize, or shift into the subnormal range with sticky.
  logic signed [9:0] e_norm, sh_amt, r_amt;
  logic [47:0]       norm, rmask;
  logic              xst;
  logic [7:0]        efield;
  logic              ovf;

  always_comb begin
    e_norm = epre2_r - signed'({4'b0000, lz2_r});
    sh_amt = epre2_r - 10'sd1;
    r_amt  = 10'sd1 - epre2_r;
    xst    = 1'b0;
    rmask  = 48'd0;
    ovf    = (e_norm >= 10'sd255);
    if (e_norm >= 10'sd1) begin
      norm   = prod2_r << lz2_r;
      efield = e_norm[7:0];
    end else begin
      efield = 8'd0;
      if (sh_amt >= 10'sd0) begin
        norm = prod2_r << sh_amt[5:0];
      end else if (r_amt >= 10'sd48) begin
        norm = 48'd0;
        xst  = |prod2_r;
      end else begin
        rmask = (48'd1 << r_amt[5:0]) - 48'd1;
        norm  = prod2_r >> r_amt[5:0];
        xst   = |(prod2_r & rmask);
      end
    end
  end

  logic [47:0] norm3_r;
  logic [7:0]  ef3_r;
  logic        xst3_r, ovf3_r, sgn3_r, spec3_r;
  logic [31:0] sbits3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      norm3_r  <= norm;
      ef3_r    <= efield;
      xst3_r   <= xst;
      ovf3_r   <= ovf;
      sgn3_r   <= sgn2_r;
      spec3_r  <= spec2_r;
      sbits3_r <= sbits2_r;
    end
  end

  // Stage 4: round to nearest even and pack; the carry may step the exponent.
  logic        inc;
  logic [30:0] mag;
  logic [31:0] res;

  always_comb begin
    inc = norm3_r[23] && ((|norm3_r[22:0]) || xst3_r || norm3_r[24]);
    mag = {ef3_r, norm3_r[46:24]} + {30'd0, inc};
    if (spec3_r) begin
      res = sbits3_r;
    end else if (ovf3_r) begin
      res = {sgn3_r, 8'hff, 23'd0};
    end else begin
      res = {sgn3_r, mag};
    end
  end

  logic [31:0] res4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res4_r <= res;
    end
  end

  assign p_bits = res4_r;

endmodule

// ===== design/frsq_fadd.sv =====
// Six-stage single-precision adder, round to nearest even, subnormals kept.
`timescale 1ns / 1ps
module frsq_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a_bits,
  input  logic [31:0] b_bits,
  output logic [31:0] s_bits
);
  import frsq_pkg::*;

  // Stage 1: unpack, special operands, order by magnitude.
  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  logic [31:0] big, sml;
  logic        spec;
  logic [31:0] spec_bits;
  logic [7:0]  ebig, esml;

  always_comb begin
    a_nan = (&a_bits[30:23]) && (|a_bits[22:0]);
    b_nan = (&b_bits[30:23]) && (|b_bits[22:0]);
    a_inf = (&a_bits[30:23]) && !(|a_bits[22:0]);
    b_inf = (&b_bits[30:23]) && !(|b_bits[22:0]);
    a_big = (a_bits[30:0] >= b_bits[30:0]);
    big   = a_big ? a_bits : b_bits;
    sml   = a_big ? b_bits : a_bits;
    ebig  = (|big[30:23]) ? big[30:23] : 8'd1;
    esml  = (|sml[30:23]) ? sml[30:23] : 8'd1;
    spec  = 1'b1;
    if (a_nan || b_nan || (a_inf && b_inf && (a_bits[31] != b_bits[31]))) begin
      spec_bits = CANON_NAN;
    end else if (a_inf) begin
      spec_bits = a_bits;
    end else if (b_inf) begin
      spec_bits = b_bits;
    end else begin
      spec      = 1'b0;
      spec_bits = CANON_NAN;
    end
  end

  logic        sb1_r, ss1_r, spec1_r;
  logic [7:0]  eb1_r, d1_r;
  logic [23:0] mb1_r, ms1_r;
  logic [31:0] sbits1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r    <= big[31];
      ss1_r    <= sml[31];
      eb1_r    <= ebig;
      d1_r     <= ebig - esml;
      mb1_r    <= {|big[30:23], big[22:0]};
      ms1_r    <= {|sml[30:23], sml[22:0]};
      spec1_r  <= spec;
      sbits1_r <= spec_bits;
    end
  end

  // Stage 2: align the smaller operand, folding lost bits into sticky.
  logic [26:0] full, amask, ms_al;

  always_comb begin
    full  = {ms1_r, 3'b000};
    amask = 27'd0;
    if (d1_r >= 8'd27) begin
      ms_al = {26'd0, |ms1_r};
    end else begin
      amask = (27'd1 << d1_r[4:0]) - 27'd1;
      ms_al = (full >> d1_r[4:0]) | {26'd0, |(full & amask)};
    end
  end

  logic        sb2_r, sub2_r, zs2_r, spec2_r;
  logic [7:0]  eb2_r;
  logic [26:0] mb2_r, ms2_r;
  logic [31:0] sbits2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r    <= sb1_r;
      sub2_r   <= sb1_r ^ ss1_r;
      zs2_r    <= sb1_r & ss1_r;
      eb2_r    <= eb1_r;
      mb2_r    <= {mb1_r, 3'b000};
      ms2_r    <= ms_al;
      spec2_r  <= spec1_r;
      sbits2_r <= sbits1_r;
    end
  end

  // Stage 3: add or subtract magnitudes.
  logic [27:0] sum3_r;
  logic        sb3_r, zs3_r, spec3_r;
  logic [7:0]  eb3_r;
  logic [31:0] sbits3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r   <= sub2_r ? ({1'b0, mb2_r} - {1'b0, ms2_r})
                         : ({1'b0, mb2_r} + {1'b0, ms2_r});
      sb3_r    <= sb2_r;
      zs3_r    <= zs2_r;
      eb3_r    <= eb2_r;
      spec3_r  <= spec2_r;
      sbits3_r <= sbits2_r;
    end
  end

  // Stage 4: pick the normalizing shift, limited at the subnormal boundary.
  logic [4:0] lz, lsh;
  logic [8:0] e_new;

  always_comb begin
    lz = lzc27(sum3_r[26:0]);
    if (sum3_r[27]) begin
      lsh   = 5'd0;
      e_new = {1'b0, eb3_r} + 9'd1;
    end else begin
      lsh   = ({3'b000, lz} < eb3_r) ? lz : 5'(eb3_r - 8'd1);
      e_new = {1'b0, eb3_r} - {4'd0, lsh};
    end
  end

  logic [27:0] sum4_r;
  logic [4:0]  lsh4_r;
  logic [8:0]  e4_r;
  logic        sb4_r, zs4_r, spec4_r;
  logic [31:0] sbits4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum4_r   <= sum3_r;
      lsh4_r   <= lsh;
      e4_r     <= e_new;
      sb4_r    <= sb3_r;
      zs4_r    <= zs3_r;
      spec4_r  <= spec3_r;
      sbits4_r <= sbits3_r;
    end
  end

  // Stage 5: apply the shift.
  logic [26:0] sn;

  always_comb begin
    if (sum4_r[27]) begin
      sn = {sum4_r[27:2], sum4_r[1] | sum4_r[0]};
    end else begin
      sn = sum4_r[26:0] << lsh4_r;
    end
  end

  logic [26:0] sn5_r;
  logic [8:0]  ef5_r;
  logic        zero5_r, sb5_r, zs5_r, spec5_r;
  logic [31:0] sbits5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sn5_r    <= sn;
      ef5_r    <= sn[26] ? e4_r : 9'd0;
      zero5_r  <= !(|sum4_r);
      sb5_r    <= sb4_r;
      zs5_r    <= zs4_r;
      spec5_r  <= spec4_r;
      sbits5_r <= sbits4_r;
    end
  end

  // Stage 6: round to nearest even and pack.
  logic        inc;
  logic [30:0] mag;
  logic [31:0] res;

  always_comb begin
    inc = sn5_r[2] && ((|sn5_r[1:0]) || sn5_r[3]);
    mag = {ef5_r[7:0], sn5_r[25:3]} + {30'd0, inc};
    if (spec5_r) begin
      res = sbits5_r;
    end else if (zero5_r) begin
      res = {zs5_r, 31'd0};
    end else if (ef5_r >= 9'd255) begin
      res = {sb5_r, 8'hff, 23'd0};
    end else begin
      res = {sb5_r, mag};
    end
  end

  logic [31:0] res6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res6_r <= res;
    end
  end

  assign s_bits = res6_r;

endmodule

// ===== design/fast_inverse_square_root_top.sv =====
// Top level of the pipelined fast reciprocal square root.
`timescale 1ns / 1ps
// Takes one single-precision bit pattern per word and returns the classic
// 0x5f3759df estimate refined by one Newton step, with every operation rounded
// to nearest even and subnormals kept; a NaN result is always 0x7FC00000.
// The block accepts one word every cycle while the output does not stall, and each
// result goes through four multiplier passes of four stages and one adder of
// six stages in series. A stall on the output freezes the whole pipeline.
module fast_inverse_square_root_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_y_bits
);
  import frsq_pkg::*;

  logic en;
  logic [TOTAL_LAT-1:0] vld_r, vld_nxt;
  logic [31:0] ydl_r [YDL_LEN];
  logic [31:0] guess, halfx, t1, t2, t3;

  // The pipeline moves unless a finished word waits at the output.
  assign en       = !(vld_r[TOTAL_LAT-1] && out_stall);
  assign in_stall = !en;

  // Valid bits travel with the data.
  always_comb begin
    vld_nxt = {vld_r[TOTAL_LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Initial estimate from integer arithmetic on the bit pattern.
  assign guess = MAGIC_GUESS - {in_x_bits[31], in_x_bits[31:1]};

  // The estimate rides alongside until each step that needs it.
  always_ff @(posedge clk) begin
    if (en) begin
      ydl_r[0] <= guess;
      for (int i = 1; i < YDL_LEN; i++) begin
        ydl_r[i] <= ydl_r[i-1];
      end
    end
  end

  // halfx = 0.5 * x
  frsq_fmul u_mul_half (
    .clk    (clk),
    .en     (en),
    .a_bits (in_x_bits),
    .b_bits (FP_HALF),
    .p_bits (halfx)
  );

  // t = halfx * y
  frsq_fmul u_mul_hy (
    .clk    (clk),
    .en     (en),
    .a_bits (halfx),
    .b_bits (ydl_r[MUL_LAT-1]),
    .p_bits (t1)
  );

  // t = t * y
  frsq_fmul u_mul_ty (
    .clk    (clk),
    .en     (en),
    .a_bits (t1),
    .b_bits (ydl_r[2*MUL_LAT-1]),
    .p_bits (t2)
  );

  // t = 1.5 - t
  frsq_fadd u_sub (
    .clk    (clk),
    .en     (en),
    .a_bits (FP_THREE_HALF),
    .b_bits ({~t2[31], t2[30:0]}),
    .s_bits (t3)
  );

  // y = y * t
  frsq_fmul u_mul_out (
    .clk    (clk),
    .en     (en),
    .a_bits (ydl_r[YDL_LEN-1]),
    .b_bits (t3),
    .p_bits (out_y_bits)
  );

  assign out_valid = vld_r[TOTAL_LAT-1];

endmodule
